@@ rtl/core/sedt_pkg.sv @@
`timescale 1ns / 1ps

package sedt_pkg;

  // Pixel and line geometry.
  localparam int PIX_W          = 8;
  localparam int MAX_LINE_WIDTH = 1024;
  localparam int LINE_AW        = $clog2(MAX_LINE_WIDTH);

  // Configuration register widths and reset values.
  localparam int FW_W = 11;
  localparam int FH_W = 12;
  localparam int TH_W = 8;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST    = FW_W'(640);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST   = FH_W'(480);
  localparam logic [TH_W-1:0] EDGE_THRESHOLD_RST = TH_W'(130);

  // Configuration port.
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd2;

  // Arithmetic widths: a Sobel sum stays within +/-1020, half the sum of
  // squares within 20 bits, and the root is saturated to eight bits.
  localparam int GRAD_W = 11;
  localparam int SQ_W   = 20;
  localparam int ROOT_W = 8;
  localparam int SQ_SAT = 1 << (2 * ROOT_W);

  typedef logic [8:0][PIX_W-1:0]    win_t;
  typedef logic signed [GRAD_W-1:0] grad_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } root_stat_t;

  function automatic grad_t pix_ext(input logic [PIX_W-1:0] p);
    return $signed({{(GRAD_W-PIX_W){1'b0}}, p});
  endfunction

  // Horizontal kernel { -1, 0, 1, -2, 0, 2, -1, 0, 1 }, row-major, top row first.
  function automatic grad_t sobel_gx(input win_t w);
    return (pix_ext(w[2]) + (pix_ext(w[5]) <<< 1) + pix_ext(w[8]))
         - (pix_ext(w[0]) + (pix_ext(w[3]) <<< 1) + pix_ext(w[6]));
  endfunction

  // Vertical kernel { -1, -2, -1, 0, 0, 0, 1, 2, 1 }.
  function automatic grad_t sobel_gy(input win_t w);
    return (pix_ext(w[6]) + (pix_ext(w[7]) <<< 1) + pix_ext(w[8]))
         - (pix_ext(w[0]) + (pix_ext(w[1]) <<< 1) + pix_ext(w[2]));
  endfunction

endpackage

@@ rtl/core/sedt_isqrt.sv @@
`timescale 1ns / 1ps

module sedt_isqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [sedt_pkg::SQ_W-1:0] q,
  output sedt_pkg::root_stat_t    stat
);
  import sedt_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t              state_r;
  logic [SQ_W-1:0]     q_r;
  logic [ROOT_W-1:0]   root_r;
  logic [2:0]          bit_r;
  logic                done_r;
  logic [ROOT_W-1:0]   trial;
  logic [2*ROOT_W-1:0] trial_sq;

  // One result bit per cycle, most significant first.
  assign trial    = root_r | (ROOT_W'(1) << bit_r);
  assign trial_sq = trial * trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            q_r   <= q;
            bit_r <= 3'(ROOT_W - 1);
            if (32'(q) >= SQ_SAT) begin
              root_r <= '1;
              done_r <= 1'b1;
            end else begin
              root_r  <= '0;
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (32'(trial_sq) <= 32'(q_r)) begin
            root_r <= trial;
          end
          if (bit_r == 3'd0) begin
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            bit_r <= bit_r - 3'd1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign stat.done = done_r;
  assign stat.root = root_r;

endmodule

@@ rtl/core/sobel_edge_threshold.sv @@
`timescale 1ns / 1ps
// An interior pixel's result passes the update, gradient, square, root and emit states (the root
// steps are skipped when the magnitude saturates); only a stalled output beat holds it back further.
// The block takes one pixel at a time; a border pixel only needs the line memory read-modify-write,
// while an interior pixel also waits for the bit-per-cycle square root unit.
// Reset: synchronous, active low; then a pass zeroes all 1024 line memory entries with in_stall high.

module sobel_edge_threshold (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_pixel,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_magnitude,
  output logic                        out_edge_res,
  output logic                        out_end_of_frame,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [sedt_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [sedt_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [sedt_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import sedt_pkg::*;

  // The sequencer handles one pixel at a time. A pixel's column reads one
  // line memory entry that packs the two rows above it; the entry is written
  // back in the next cycle, before another pixel can be accepted, so the
  // read of the next pixel always sees the updated row data.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_GRAD,
    ST_SQUARE,
    ST_ROOT,
    ST_EMIT
  } state_t;

  localparam int COL_W = LINE_AW;
  localparam int ROW_W = FH_W;

  state_t state_r;

  // Configuration registers.
  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;
  logic [TH_W-1:0] edge_threshold_r;

  // Position of the next pixel in the frame.
  logic [COL_W-1:0] column_r;
  logic [ROW_W-1:0] row_r;

  // Per-pixel working registers.
  logic [PIX_W-1:0] pix_r;
  logic [COL_W-1:0] idx_r;
  logic             emit_r;
  logic             eof_r;
  win_t             win_r;
  grad_t            gx_r;
  grad_t            gy_r;
  logic [COL_W-1:0] clr_addr_r;

  // Result register.
  logic              out_valid_r;
  logic [ROOT_W-1:0] out_magnitude_r;
  logic              out_edge_res_r;
  logic              out_end_of_frame_r;

  // Line memory: bits [15:8] hold the row two above, bits [7:0] the row above.
  logic [2*PIX_W-1:0] line_mem [MAX_LINE_WIDTH];
  logic [2*PIX_W-1:0] rd_data_r;
  logic               mem_we;
  logic [COL_W-1:0]   mem_waddr;
  logic [2*PIX_W-1:0] mem_wdata;

  // Effective geometry and the position of the incoming pixel.
  logic [FW_W-1:0]  w_eff;
  logic [FH_W-1:0]  h_eff;
  logic [COL_W-1:0] c_cur;
  logic [ROW_W-1:0] r_cur;
  logic             wrap_row;
  logic             wrap_frame;
  logic             emit_cur;
  logic [COL_W-1:0] column_nxt;
  logic [ROW_W-1:0] row_nxt;
  logic             in_accept;
  logic             cfg_write;
  logic             out_load;

  // Squares and root.
  logic signed [2*GRAD_W-1:0] sqx;
  logic signed [2*GRAD_W-1:0] sqy;
  logic [2*GRAD_W-1:0]        sq_sum;
  logic                       root_start;
  root_stat_t                 root_stat;

  // ------------------------------------------------------------------
  // Configuration port. Register i sits at byte address 4*i; the port
  // never waits.
  // ------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_paddr[CFG_AW-1:2])
      REG_FRAME_WIDTH:    cfg_prdata = CFG_DW'(frame_width_r);
      REG_FRAME_HEIGHT:   cfg_prdata = CFG_DW'(frame_height_r);
      REG_EDGE_THRESHOLD: cfg_prdata = CFG_DW'(edge_threshold_r);
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= FRAME_WIDTH_RST;
      frame_height_r   <= FRAME_HEIGHT_RST;
      edge_threshold_r <= EDGE_THRESHOLD_RST;
    end else if (cfg_write) begin
      unique case (cfg_paddr[CFG_AW-1:2])
        REG_FRAME_WIDTH:    frame_width_r    <= cfg_pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT:   frame_height_r   <= cfg_pwdata[FH_W-1:0];
        REG_EDGE_THRESHOLD: edge_threshold_r <= cfg_pwdata[TH_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Geometry. The width is clamped to 3..MAX_LINE_WIDTH and the height is
  // raised to at least 3. A counter left at or past a bound that shrank
  // is pulled back to the last column or row.
  // ------------------------------------------------------------------
  always_comb begin
    if (frame_width_r < FW_W'(3)) begin
      w_eff = FW_W'(3);
    end else if (32'(frame_width_r) > MAX_LINE_WIDTH) begin
      w_eff = FW_W'(MAX_LINE_WIDTH);
    end else begin
      w_eff = frame_width_r;
    end
    h_eff = (frame_height_r < FH_W'(3)) ? FH_W'(3) : frame_height_r;

    c_cur = (32'(column_r) >= 32'(w_eff)) ? COL_W'(w_eff - FW_W'(1)) : column_r;
    r_cur = (32'(row_r) >= 32'(h_eff)) ? ROW_W'(h_eff - FH_W'(1)) : row_r;

    wrap_row   = (32'(c_cur) + 32'd1) >= 32'(w_eff);
    wrap_frame = wrap_row && ((32'(r_cur) + 32'd1) >= 32'(h_eff));
    // The window is centered one row and one column behind the incoming
    // pixel, so only pixels past the first two rows and columns produce a result.
    emit_cur   = (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));

    if (wrap_row) begin
      column_nxt = '0;
      row_nxt    = wrap_frame ? '0 : r_cur + ROW_W'(1);
    end else begin
      column_nxt = c_cur + COL_W'(1);
      row_nxt    = r_cur;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // ------------------------------------------------------------------
  // Line memory. After reset a clearing pass writes zero into every entry.
  // ------------------------------------------------------------------
  always_comb begin
    mem_we    = (state_r == ST_CLEAR) || (state_r == ST_UPDATE);
    mem_waddr = (state_r == ST_CLEAR) ? clr_addr_r : idx_r;
    mem_wdata = (state_r == ST_CLEAR) ? '0 : {rd_data_r[PIX_W-1:0], pix_r};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      rd_data_r <= line_mem[c_cur];
    end
  end

  // ------------------------------------------------------------------
  // Gradient magnitude. Both squares are summed and halved in the cycle
  // that hands the value to the root unit.
  // ------------------------------------------------------------------
  assign sqx        = gx_r * gx_r;
  assign sqy        = gy_r * gy_r;
  assign sq_sum     = $unsigned(sqx) + $unsigned(sqy);
  assign root_start = (state_r == ST_SQUARE);

  sedt_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .q     (sq_sum[SQ_W:1]),
    .stat  (root_stat)
  );

  // The result register is loaded when it is empty or its beat is taken
  // in the same cycle.
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  // ------------------------------------------------------------------
  // Sequencer.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      column_r    <= '0;
      row_r       <= '0;
      win_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + COL_W'(1);
          if (clr_addr_r == COL_W'(MAX_LINE_WIDTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            pix_r    <= in_pixel;
            idx_r    <= c_cur;
            emit_r   <= emit_cur;
            eof_r    <= wrap_frame;
            column_r <= column_nxt;
            row_r    <= row_nxt;
            state_r  <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          // Slide the window one column and bring in the new right column.
          win_r[0] <= win_r[1];
          win_r[1] <= win_r[2];
          win_r[2] <= rd_data_r[2*PIX_W-1:PIX_W];
          win_r[3] <= win_r[4];
          win_r[4] <= win_r[5];
          win_r[5] <= rd_data_r[PIX_W-1:0];
          win_r[6] <= win_r[7];
          win_r[7] <= win_r[8];
          win_r[8] <= pix_r;
          state_r  <= emit_r ? ST_GRAD : ST_IDLE;
        end
        ST_GRAD: begin
          gx_r    <= sobel_gx(win_r);
          gy_r    <= sobel_gy(win_r);
          state_r <= ST_SQUARE;
        end
        ST_SQUARE: begin
          state_r <= ST_ROOT;
        end
        ST_ROOT: begin
          if (root_stat.done) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            out_magnitude_r    <= root_stat.root;
            out_edge_res_r     <= (root_stat.root >= edge_threshold_r);
            out_end_of_frame_r <= eof_r;
            state_r            <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_magnitude    = out_magnitude_r;
  assign out_edge_res     = out_edge_res_r;
  assign out_end_of_frame = out_end_of_frame_r;

endmodule

@@ rtl/core/sedt_checker.sv @@
`timescale 1ns / 1ps

module sedt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_magnitude,
  input logic       out_edge_res,
  input logic       out_end_of_frame
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_magnitude)
      && $stable(out_edge_res) && $stable(out_end_of_frame))
    else $error("stalled result beat changed");

  // One pixel at a time: an accepted beat closes the input for the next cycle.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a pixel was in flight");

  // The line memory clearing pass keeps the input closed right after reset.
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_stall)
    else $error("input open during the clearing pass");

  // A new result only appears when the sequencer was busy just before it.
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a pixel in flight");

  // A saturated magnitude always meets any threshold.
  a_sat_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_magnitude == 8'd255) |-> out_edge_res)
    else $error("saturated magnitude not flagged as edge");

endmodule

bind sobel_edge_threshold sedt_checker u_sedt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_magnitude    (out_magnitude),
  .out_edge_res     (out_edge_res),
  .out_end_of_frame (out_end_of_frame)
);
